/* hw/rtl/nurbs_pkg.sv */
// Shared types and fixed-point constants for the rational bicubic surface evaluator.
package nurbs_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  // Fixed-point widths that follow from the field formats.
  localparam int KSCALE_SH = 16;                 // knots are held in Q16 half units
  localparam int LR_W      = 19;                 // knot distance, at most six half units
  localparam int BAS_W     = 31;                 // basis value, Q30
  localparam int C_W       = 2 * BAS_W - 30;     // rounded basis product, Q30
  localparam int W_W       = 24;                 // control point weight, Q8.16
  localparam int QP_W      = W_W + C_W;          // weight times basis product
  localparam int Q_W       = QP_W - 26;          // weighted basis, Q20
  localparam int SUM_W     = 64;                 // coordinate accumulators
  localparam int WSUM_W    = 34;                 // weight accumulator
  localparam int DIV_NW    = 65;                 // shared divider dividend width
  localparam int DIV_DW    = 34;                 // shared divider divisor width

  localparam logic [BAS_W-1:0] ONE_Q30 = BAS_W'(1) << 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINTS_U = 3'd0,
    REG_POINTS_V = 3'd1,
    REG_WRAP_U   = 3'd2,
    REG_WRAP_V   = 3'd3,
    REG_NORM_U   = 3'd4,
    REG_NORM_V   = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP,
    ST_CLAMP,
    ST_UP,
    ST_DN,
    ST_BINIT,
    ST_BMUL,
    ST_BSTART,
    ST_BWAIT,
    ST_AADDR,
    ST_AREAD,
    ST_AQ,
    ST_ASUM,
    ST_FSTART,
    ST_FWAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [W_W-1:0]     w;
  } point_t;

endpackage

/* hw/rtl/nurbs_div.sv */
// Restoring divider, one quotient bit per cycle.
module nurbs_div #(
  parameter int NW = 65,
  parameter int DW = 34
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem_r;
  logic [NW-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [DW:0] rem_sh;
  logic [DW:0] diff;
  logic        ge;

  assign rem_sh = {rem_r, num_r[NW-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign diff   = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      num_r <= num_r << 1;
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* hw/rtl/nurbs_store.sv */
// Control point memory: one write port, one registered read port.
module nurbs_store #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  nurbs_pkg::point_t        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output nurbs_pkg::point_t        rdata
);
  import nurbs_pkg::*;

  point_t mem_r [DEPTH];
  point_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/bicubic_nurbs_surface_eval.sv */
// Top level of the rational bicubic B-spline surface evaluator.
//
// A load beat (in_command low) writes the next control point of the grid, in row
// order with the u index fastest; busy stays low and loads past the grid are
// dropped. An evaluate beat (in_command high) raises busy and returns one result
// beat, out_valid high for exactly one cycle. Evaluation runs on the single
// restoring divider, which delivers one quotient bit per cycle and is shared by
// the 24 knot divisions of the de Boor basis and the three final divisions by the
// weight sum, skipped when that sum is zero; the knot span walk steps over one
// knot at a time. The receiver cannot stall the result, so it must take the beat
// in the cycle it appears. Configuration is to be written by the user only while
// busy is low; the block itself does not enforce this. Every write to a known
// register index also rewinds the load position and the remembered knot spans.
// Grid entries that were never loaded read back undefined.
module bicubic_nurbs_surface_eval #(
  parameter int MAX_PER_AXIS = 16,
  parameter int STORE_DEPTH  = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_command,
  input  logic signed [31:0]                   in_coord_x,
  input  logic signed [31:0]                   in_coord_y,
  input  logic signed [31:0]                   in_coord_z,
  input  logic [23:0]                          in_point_weight,
  input  logic signed [31:0]                   in_param_u,
  input  logic signed [31:0]                   in_param_v,
  output logic                                 out_valid,
  output logic signed [31:0]                   out_pos_x,
  output logic signed [31:0]                   out_pos_y,
  output logic signed [31:0]                   out_pos_z,
  output logic                                 out_weight_zero,
  input  logic                                 cfg_we,
  input  logic [nurbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nurbs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import nurbs_pkg::*;

  // Axis index width covers the point count plus the extra cyclic knots.
  localparam int AXW  = $clog2(MAX_PER_AXIS + 7);
  localparam int KW   = AXW + 2;
  localparam int TW   = KW + KSCALE_SH;
  localparam int SCW  = AXW + 1;
  localparam int MPW  = 32 + SCW + 1;
  localparam int IDXW = $clog2(MAX_PER_AXIS * MAX_PER_AXIS);
  localparam int LPW  = $clog2(MAX_PER_AXIS * MAX_PER_AXIS + 1);
  localparam int AW   = $clog2(STORE_DEPTH);
  localparam int PW   = BAS_W + LR_W;

  typedef logic [AXW-1:0]       ax_t;
  typedef logic signed [KW-1:0] knot_t;
  typedef logic signed [TW-1:0] tval_t;

  // Control point slot that knot index k refers to.
  function automatic ax_t slot_f(input ax_t n, input logic cyc, input ax_t k);
    ax_t r;
    if (cyc) begin
      if (k < AXW'(3)) begin
        r = n - AXW'(3) + k;
      end else if (k >= n + AXW'(3)) begin
        r = k - n - AXW'(3);
      end else begin
        r = k - AXW'(3);
      end
    end else begin
      if (k < AXW'(2)) begin
        r = '0;
      end else if (k >= n + AXW'(2)) begin
        r = n - AXW'(1);
      end else begin
        r = k - AXW'(2);
      end
    end
    if (r >= n) begin
      r = n - AXW'(1);
    end
    return r;
  endfunction

  // Knot position in half knot units.
  function automatic knot_t knot_f(input ax_t n, input logic cyc, input ax_t k);
    knot_t kv;
    if (cyc) begin
      kv = knot_t'({1'b0, k, 1'b0}) - knot_t'({2'b00, n}) - knot_t'(5);
    end else begin
      kv = knot_t'({1'b0, slot_f(n, cyc, k), 1'b0});
    end
    return kv;
  endfunction

  function automatic tval_t kscale_f(input knot_t kv);
    return tval_t'({kv, {KSCALE_SH{1'b0}}});
  endfunction

  function automatic ax_t top_f(input ax_t n, input logic cyc);
    return cyc ? n + AXW'(2) : n;
  endfunction

  // Configuration and persistent state.
  logic [CFG_DATA_W-1:0] points_u_r, points_v_r;
  logic                  wrap_u_r, wrap_v_r, norm_u_r, norm_v_r;
  logic [LPW-1:0]        load_pos_r;
  ax_t                   span_u_r, span_v_r;
  state_t                state_r, state_nxt;

  // Evaluation datapath registers.
  logic signed [31:0]    pu_r, pv_r;
  logic signed [MPW-1:0] tmu_r, tmv_r;
  tval_t                 tu_r, tv_r;
  logic                  ax_sel_r;
  logic [BAS_W-1:0]      bas_r [2][4];
  logic [1:0]            j_r, r_r, pn_r, pm_r, fc_r;
  logic                  phase_r;
  logic [BAS_W-1:0]      saved_r, x_r;
  logic [PW-1:0]         prod_r;
  logic [LR_W:0]         d_r;
  logic [IDXW-1:0]       idx_r;
  logic                  idx_ok_r;
  logic [C_W-1:0]        c_r;
  logic [Q_W-1:0]        q_r;
  logic [WSUM_W-1:0]     wsum_r;
  logic signed [SUM_W-1:0] sx_r, sy_r, sz_r;
  logic signed [31:0]    pos_x_r, pos_y_r, pos_z_r;
  logic                  wz_r;

  // Axis decode.
  ax_t nu_c, nv_c, topu_c, topv_c;
  logic cycu_c, cycv_c;
  logic [SCW-1:0] scu_c, scv_c;

  assign nu_c = (points_u_r < CFG_DATA_W'(2)) ? AXW'(2) :
                ((int'(points_u_r) > MAX_PER_AXIS) ? AXW'(MAX_PER_AXIS) : AXW'(points_u_r));
  assign nv_c = (points_v_r < CFG_DATA_W'(2)) ? AXW'(2) :
                ((int'(points_v_r) > MAX_PER_AXIS) ? AXW'(MAX_PER_AXIS) : AXW'(points_v_r));
  assign cycu_c = wrap_u_r && (nu_c >= AXW'(3));
  assign cycv_c = wrap_v_r && (nv_c >= AXW'(3));
  assign topu_c = top_f(nu_c, cycu_c);
  assign topv_c = top_f(nv_c, cycv_c);
  assign scu_c = !norm_u_r ? SCW'(2) : (cycu_c ? SCW'(nu_c) : SCW'({nu_c, 1'b0}) - SCW'(2));
  assign scv_c = !norm_v_r ? SCW'(2) : (cycv_c ? SCW'(nv_c) : SCW'({nv_c, 1'b0}) - SCW'(2));

  // Parameter clamping limits, first and last reachable knots.
  tval_t lou_c, hiu_c, lov_c, hiv_c;
  assign lou_c = kscale_f(knot_f(nu_c, cycu_c, AXW'(2)));
  assign hiu_c = kscale_f(knot_f(nu_c, cycu_c, topu_c + AXW'(1)));
  assign lov_c = kscale_f(knot_f(nv_c, cycv_c, AXW'(2)));
  assign hiv_c = kscale_f(knot_f(nv_c, cycv_c, topv_c + AXW'(1)));

  // Selected axis for the span walk and the basis build.
  ax_t   ax_n, ax_s, ax_top;
  logic  ax_cyc;
  tval_t ax_tv;
  assign ax_n   = ax_sel_r ? nv_c : nu_c;
  assign ax_cyc = ax_sel_r ? cycv_c : cycu_c;
  assign ax_s   = ax_sel_r ? span_v_r : span_u_r;
  assign ax_top = ax_sel_r ? topv_c : topu_c;
  assign ax_tv  = ax_sel_r ? tv_r : tu_r;

  logic up_go, dn_go;
  assign up_go = (ax_s < ax_top) &&
                 (kscale_f(knot_f(ax_n, ax_cyc, ax_s + AXW'(1))) <= ax_tv);
  assign dn_go = (ax_s > AXW'(2)) && (kscale_f(knot_f(ax_n, ax_cyc, ax_s)) >= ax_tv);

  // Knot distances for one de Boor step.
  logic [1:0]      jmr_c;
  ax_t             kl_c, kr_c;
  tval_t           lw_c, rw_c;
  logic [LR_W-1:0] left_c, right_c, lr_sel;
  logic [LR_W:0]   dsum_c, d_c;
  assign jmr_c  = j_r - r_r;
  assign kl_c   = ax_s + AXW'(1) - AXW'(jmr_c);
  assign kr_c   = ax_s + AXW'(r_r) + AXW'(1);
  assign lw_c   = ax_tv - kscale_f(knot_f(ax_n, ax_cyc, kl_c));
  assign rw_c   = kscale_f(knot_f(ax_n, ax_cyc, kr_c)) - ax_tv;
  assign left_c  = lw_c[LR_W-1:0];
  assign right_c = rw_c[LR_W-1:0];
  assign lr_sel  = phase_r ? left_c : right_c;
  assign dsum_c  = {1'b0, left_c} + {1'b0, right_c};
  assign d_c     = (dsum_c == '0) ? (LR_W + 1)'(1) : dsum_c;

  logic bas_last;
  assign bas_last = phase_r && (r_r + 2'd1 == j_r) && (j_r == 2'd3);

  // Grid index of one of the sixteen contributing points.
  ax_t slu_c, slv_c;
  logic [IDXW-1:0] idx_c;
  assign slu_c = slot_f(nu_c, cycu_c, span_u_r - AXW'(1) + AXW'(pn_r));
  assign slv_c = slot_f(nv_c, cycv_c, span_v_r - AXW'(1) + AXW'(pm_r));
  assign idx_c = IDXW'(slu_c) + IDXW'(slv_c) * IDXW'(nu_c);

  // Store access.
  point_t mem_wdata, mem_rdata;
  logic   mem_we, mem_re;
  logic   load_ok;
  assign load_ok = (int'(load_pos_r) < int'(nu_c) * int'(nv_c)) &&
                   (int'(load_pos_r) < STORE_DEPTH);
  assign mem_wdata.x = in_coord_x;
  assign mem_wdata.y = in_coord_y;
  assign mem_wdata.z = in_coord_z;
  assign mem_wdata.w = in_point_weight;

  nurbs_store #(.DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(load_pos_r)),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (AW'(idx_r)),
    .rdata (mem_rdata)
  );

  // Weighting arithmetic.
  logic [2*BAS_W-1:0]      cprod_c, cround_c;
  logic [QP_W-1:0]         qprod_c, qround_c;
  logic signed [62:0]      xp_c, yp_c, zp_c;
  assign cprod_c  = bas_r[0][pn_r] * bas_r[1][pm_r];
  assign cround_c = cprod_c + ((2 * BAS_W)'(1) << 29);
  assign qprod_c  = mem_rdata.w * c_r;
  assign qround_c = qprod_c + (QP_W'(1) << 25);
  assign xp_c = mem_rdata.x * $signed({1'b0, q_r});
  assign yp_c = mem_rdata.y * $signed({1'b0, q_r});
  assign zp_c = mem_rdata.z * $signed({1'b0, q_r});

  // Final rounded division by the weight sum.
  logic signed [SUM_W-1:0] fsum_c;
  logic [SUM_W-1:0]        fmag_c;
  logic [DIV_NW-1:0]       fnum_c;
  assign fsum_c = (fc_r == 2'd0) ? sx_r : ((fc_r == 2'd1) ? sy_r : sz_r);
  assign fmag_c = fsum_c[SUM_W-1] ? SUM_W'(-fsum_c) : SUM_W'(fsum_c);
  assign fnum_c = DIV_NW'(fmag_c) + DIV_NW'(wsum_r >> 1);

  logic              div_start, div_busy, div_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den;

  nurbs_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  logic signed [31:0] sat_c;
  always_comb begin
    if (fsum_c[SUM_W-1]) begin
      sat_c = (div_quo > DIV_NW'(33'h0_8000_0000)) ? 32'sh8000_0000 : -$signed(div_quo[31:0]);
    end else begin
      sat_c = (div_quo > DIV_NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(div_quo[31:0]);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start && in_command) state_nxt = ST_MAP;
      ST_MAP:    state_nxt = ST_CLAMP;
      ST_CLAMP:  state_nxt = ST_UP;
      ST_UP:     if (!up_go) state_nxt = ST_DN;
      ST_DN:     if (!dn_go) state_nxt = ST_BINIT;
      ST_BINIT:  state_nxt = ST_BMUL;
      ST_BMUL:   state_nxt = ST_BSTART;
      ST_BSTART: state_nxt = ST_BWAIT;
      ST_BWAIT: begin
        if (div_done) begin
          if (bas_last) begin
            state_nxt = ax_sel_r ? ST_AADDR : ST_UP;
          end else begin
            state_nxt = ST_BMUL;
          end
        end
      end
      ST_AADDR:  state_nxt = ST_AREAD;
      ST_AREAD:  state_nxt = ST_AQ;
      ST_AQ:     state_nxt = ST_ASUM;
      ST_ASUM:   state_nxt = (pn_r == 2'd3 && pm_r == 2'd3) ? ST_FSTART : ST_AADDR;
      ST_FSTART: state_nxt = (wsum_r == '0) ? ST_OUT : ST_FWAIT;
      ST_FWAIT:  if (div_done) state_nxt = (fc_r == 2'd2) ? ST_OUT : ST_FSTART;
      ST_OUT:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Decoded outputs and strobes.
  always_comb begin
    busy      = state_r != ST_IDLE;
    out_valid = state_r == ST_OUT;
    mem_we    = (state_r == ST_IDLE) && start && !in_command && load_ok;
    mem_re    = state_r == ST_AREAD;
    div_start = (state_r == ST_BSTART) || ((state_r == ST_FSTART) && (wsum_r != '0));
    if (state_r == ST_FSTART) begin
      div_num = fnum_c;
      div_den = DIV_DW'(wsum_r);
    end else begin
      div_num = DIV_NW'(prod_r) + DIV_NW'(d_r >> 1);
      div_den = DIV_DW'(d_r);
    end
  end

  // Control state: configuration, load position, spans.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      points_u_r <= CFG_DATA_W'(4);
      points_v_r <= CFG_DATA_W'(4);
      wrap_u_r   <= 1'b0;
      wrap_v_r   <= 1'b0;
      norm_u_r   <= 1'b0;
      norm_v_r   <= 1'b0;
      load_pos_r <= '0;
      span_u_r   <= '0;
      span_v_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_POINTS_U: points_u_r <= cfg_data;
          REG_POINTS_V: points_v_r <= cfg_data;
          REG_WRAP_U:   wrap_u_r   <= cfg_data[0];
          REG_WRAP_V:   wrap_v_r   <= cfg_data[0];
          REG_NORM_U:   norm_u_r   <= cfg_data[0];
          REG_NORM_V:   norm_v_r   <= cfg_data[0];
          default: ;
        endcase
        if (cfg_index <= CFG_IDX_W'(REG_NORM_V)) begin
          load_pos_r <= '0;
          span_u_r   <= '0;
          span_v_r   <= '0;
        end
      end else begin
        case (state_r)
          ST_IDLE: begin
            if (mem_we) load_pos_r <= load_pos_r + LPW'(1);
          end
          ST_CLAMP: begin
            if (span_u_r > topu_c) span_u_r <= topu_c;
            if (span_v_r > topv_c) span_v_r <= topv_c;
          end
          ST_UP: begin
            if (up_go) begin
              if (ax_sel_r) span_v_r <= span_v_r + AXW'(1);
              else span_u_r <= span_u_r + AXW'(1);
            end
          end
          ST_DN: begin
            if (dn_go) begin
              if (ax_sel_r) span_v_r <= span_v_r - AXW'(1);
              else span_u_r <= span_u_r - AXW'(1);
            end else if (ax_s < AXW'(2)) begin
              if (ax_sel_r) span_v_r <= AXW'(2);
              else span_u_r <= AXW'(2);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Evaluation datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        pu_r <= in_param_u;
        pv_r <= in_param_v;
      end
      ST_MAP: begin
        tmu_r <= pu_r * $signed({1'b0, scu_c});
        tmv_r <= pv_r * $signed({1'b0, scv_c});
      end
      ST_CLAMP: begin
        tu_r <= (tmu_r < MPW'(lou_c)) ? lou_c :
                ((tmu_r > MPW'(hiu_c)) ? hiu_c : TW'(tmu_r));
        tv_r <= (tmv_r < MPW'(lov_c)) ? lov_c :
                ((tmv_r > MPW'(hiv_c)) ? hiv_c : TW'(tmv_r));
        ax_sel_r <= 1'b0;
        wsum_r   <= '0;
        sx_r     <= '0;
        sy_r     <= '0;
        sz_r     <= '0;
        pn_r     <= '0;
        pm_r     <= '0;
        fc_r     <= '0;
        wz_r     <= 1'b0;
      end
      ST_BINIT: begin
        bas_r[ax_sel_r][0] <= ONE_Q30;
        j_r     <= 2'd1;
        r_r     <= 2'd0;
        saved_r <= '0;
        phase_r <= 1'b0;
      end
      ST_BMUL: begin
        prod_r <= bas_r[ax_sel_r][r_r] * lr_sel;
        d_r    <= d_c;
      end
      ST_BWAIT: begin
        if (div_done) begin
          if (!phase_r) begin
            x_r     <= div_quo[BAS_W-1:0];
            phase_r <= 1'b1;
          end else begin
            bas_r[ax_sel_r][r_r] <= saved_r + x_r;
            phase_r <= 1'b0;
            if (r_r + 2'd1 == j_r) begin
              // Last term of this degree closes the row.
              bas_r[ax_sel_r][j_r] <= div_quo[BAS_W-1:0];
              saved_r <= '0;
              r_r     <= 2'd0;
              j_r     <= j_r + 2'd1;
              if (j_r == 2'd3 && !ax_sel_r) ax_sel_r <= 1'b1;
            end else begin
              saved_r <= div_quo[BAS_W-1:0];
              r_r     <= r_r + 2'd1;
            end
          end
        end
      end
      ST_AADDR: begin
        idx_r    <= idx_c;
        idx_ok_r <= int'(idx_c) < STORE_DEPTH;
      end
      ST_AREAD: begin
        c_r <= cround_c[2*BAS_W-1:30];
      end
      ST_AQ: begin
        q_r <= qround_c[QP_W-1:26];
      end
      ST_ASUM: begin
        if (idx_ok_r) begin
          wsum_r <= wsum_r + WSUM_W'(q_r);
          sx_r   <= sx_r + SUM_W'(xp_c);
          sy_r   <= sy_r + SUM_W'(yp_c);
          sz_r   <= sz_r + SUM_W'(zp_c);
        end
        pm_r <= pm_r + 2'd1;
        if (pm_r == 2'd3) pn_r <= pn_r + 2'd1;
      end
      ST_FSTART: begin
        if (wsum_r == '0) begin
          pos_x_r <= '0;
          pos_y_r <= '0;
          pos_z_r <= '0;
          wz_r    <= 1'b1;
        end
      end
      ST_FWAIT: begin
        if (div_done) begin
          case (fc_r)
            2'd0:    pos_x_r <= sat_c;
            2'd1:    pos_y_r <= sat_c;
            default: pos_z_r <= sat_c;
          endcase
          fc_r <= fc_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_pos_x       = pos_x_r;
  assign out_pos_y       = pos_y_r;
  assign out_pos_z       = pos_z_r;
  assign out_weight_zero = wz_r;

  // The shared divider is never restarted while a division is running.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider started while busy");

  // A result beat only follows a cycle of evaluation work.
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without evaluation");

  // Spans are inside the reachable range once the walk has finished.
  a_span_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_AADDR) |-> (span_u_r >= AXW'(2) && span_u_r <= topu_c &&
                               span_v_r >= AXW'(2) && span_v_r <= topv_c))
    else $error("knot span out of range");

  // The load position never runs past the configured grid.
  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(load_pos_r) <= int'(nu_c) * int'(nv_c)) else $error("load position past grid");

endmodule
